// ===== rtl/rcw_pkg.sv =====
// Shared types, codes and helpers for the Reno congestion window block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package rcw_pkg;

   localparam int WORD_BITS = 32;
   localparam int MSS_BITS  = 16;
   localparam int CNT_BITS  = 8;
   localparam int CSR_BITS  = 1;

   localparam logic [1:0] PHASE_SLOW_START = 2'd0;
   localparam logic [1:0] PHASE_AVOIDANCE  = 2'd1;
   localparam logic [1:0] PHASE_RECOVERY   = 2'd2;

   localparam logic CMD_ACK     = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   localparam logic [CSR_BITS-1:0] CSR_SEGMENT_SIZE      = 1'b0;
   localparam logic [CSR_BITS-1:0] CSR_INITIAL_THRESHOLD = 1'b1;

   localparam logic [MSS_BITS-1:0]  MSS_RESET = 16'd1024;
   localparam logic [WORD_BITS-1:0] THR_RESET = 32'd65535;
   localparam logic [CNT_BITS-1:0]  DUP_MAX   = 8'd255;
   localparam logic [CNT_BITS-1:0]  DUP_FAST  = 8'd3;

   typedef struct packed {
      logic take_input;
      logic load_mul;
      logic start_div;
      logic commit;
   } rcw_cmd_type;

   typedef struct packed {
      logic needs_div;
      logic div_done;
      logic out_free;
   } rcw_status_type;

   function automatic logic [WORD_BITS-1:0] sat_add(input logic [WORD_BITS-1:0] a,
                                                    input logic [WORD_BITS-1:0] b);
      logic [WORD_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WORD_BITS] ? {WORD_BITS{1'b1}} : s[WORD_BITS-1:0];
   endfunction

endpackage

// ===== rtl/rcw_ifs.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on rcw_pkg for field widths.
`timescale 1ns / 1ps

interface rcw_req_if import rcw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [WORD_BITS-1:0] ack_number;

   modport source (output valid, command, ack_number, input ready);
   modport sink   (input valid, command, ack_number, output ready);
endinterface

interface rcw_rsp_if import rcw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] window;
   logic [WORD_BITS-1:0] threshold;
   logic [1:0]           phase;
   logic                 resend_request;
   logic                 ack_needed;

   modport source (output valid, window, threshold, phase, resend_request, ack_needed,
                   input ready);
   modport sink   (input valid, window, threshold, phase, resend_request, ack_needed,
                   output ready);
endinterface

// ===== rtl/rcw_divider.sv =====
// Restoring 32-bit divider, one quotient bit per cycle.
// Depends on rcw_pkg.
`timescale 1ns / 1ps

module rcw_divider import rcw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] dividend,
   input  logic [WORD_BITS-1:0] divisor,
   output logic [WORD_BITS-1:0] quotient,
   output logic                 done
);

   localparam int STEP_BITS = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0] quo_ff, quo_in;
   logic [WORD_BITS-1:0] div_ff, div_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [WORD_BITS:0]   trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[WORD_BITS-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? WORD_BITS'(trial - {1'b0, div_ff}) : trial[WORD_BITS-1:0];
         quo_in  = {quo_ff[WORD_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(WORD_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/rcw_ctrl.sv =====
// Sequencer for one event: accept, decide, optional divide, commit.
// Depends on rcw_pkg for command and status structs.
`timescale 1ns / 1ps

module rcw_ctrl import rcw_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  rcw_status_type status,
   output rcw_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECIDE = 5'b00010,
      ST_START  = 5'b00100,
      ST_DIV    = 5'b01000,
      ST_COMMIT = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take_input = req_valid;
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.load_mul = status.needs_div;
            state_in     = status.needs_div ? ST_START : ST_COMMIT;
         end
         ST_START: begin
            cmd.start_div = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd.commit = status.out_free;
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// ===== rtl/rcw_datapath.sv =====
// Window state, segment size register, growth arithmetic and response register.
// Depends on rcw_pkg and rcw_divider.
`timescale 1ns / 1ps

module rcw_datapath import rcw_pkg::*; #(
   parameter int ACK_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rcw_cmd_type          cmd,
   output rcw_status_type       status,
   input  logic                 csr_write_en,
   input  logic [CSR_BITS-1:0]  csr_index,
   input  logic [WORD_BITS-1:0] csr_write_data,
   input  logic                 req_command,
   input  logic [WORD_BITS-1:0] req_ack_number,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_BITS-1:0] rsp_window,
   output logic [WORD_BITS-1:0] rsp_threshold,
   output logic [1:0]           rsp_phase,
   output logic                 rsp_resend_request,
   output logic                 rsp_ack_needed
);

   logic [MSS_BITS-1:0]  mss_ff;
   logic [WORD_BITS-1:0] win_ff, win_in;
   logic [WORD_BITS-1:0] thr_ff, thr_in;
   logic [1:0]           phase_ff, phase_in;
   logic [CNT_BITS-1:0]  dup_ff, dup_in;
   logic [ACK_BITS-1:0]  last_ack_ff, last_ack_in;
   logic                 cmd_ff;
   logic [ACK_BITS-1:0]  ack_ff;
   logic [WORD_BITS-1:0] prod_ff;
   logic                 out_valid_ff;
   logic [WORD_BITS-1:0] out_win_ff, out_thr_ff;
   logic [1:0]           out_phase_ff;
   logic                 out_resend_ff, out_acked_ff;

   logic                 is_dup;
   logic [CNT_BITS-1:0]  dup_inc;
   logic                 fast_rtx;
   logic                 resend, acked;
   logic [WORD_BITS-1:0] mss_word, mss_x3;
   logic [WORD_BITS-1:0] add_base, add_inc, sum;
   logic [WORD_BITS-1:0] divisor, quotient;
   logic                 div_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         mss_ff <= MSS_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SEGMENT_SIZE: mss_ff <= csr_write_data[MSS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_input) begin
         cmd_ff <= req_command;
         ack_ff <= req_ack_number[ACK_BITS-1:0];
      end
      if (cmd.load_mul) begin
         prod_ff <= mss_word * mss_word;
      end
   end

   assign divisor = (win_ff == '0) ? WORD_BITS'(1) : win_ff;

   rcw_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_div),
      .dividend (prod_ff),
      .divisor  (divisor),
      .quotient (quotient),
      .done     (div_done)
   );

   assign is_dup   = (ack_ff == last_ack_ff);
   assign dup_inc  = (dup_ff < DUP_MAX) ? dup_ff + 1'b1 : dup_ff;
   assign fast_rtx = (cmd_ff == CMD_ACK) && is_dup && (dup_inc == DUP_FAST);
   assign mss_word = {{(WORD_BITS-MSS_BITS){1'b0}}, mss_ff};
   assign mss_x3   = (mss_word << 1) + mss_word;

   always_comb begin
      add_base = fast_rtx ? (win_ff >> 1) : win_ff;
      if (fast_rtx) begin
         add_inc = mss_x3;
      end else if (!is_dup && phase_ff == PHASE_AVOIDANCE) begin
         add_inc = quotient;
      end else begin
         add_inc = mss_word;
      end
   end

   assign sum = sat_add(add_base, add_inc);

   always_comb begin
      win_in      = win_ff;
      thr_in      = thr_ff;
      phase_in    = phase_ff;
      dup_in      = dup_ff;
      last_ack_in = last_ack_ff;
      resend      = 1'b0;
      acked       = 1'b0;
      if (cmd_ff == CMD_TIMEOUT) begin
         thr_in   = (win_ff >> 1) + 1'b1;
         win_in   = mss_word;
         phase_in = PHASE_SLOW_START;
         dup_in   = '0;
      end else if (is_dup) begin
         dup_in = dup_inc;
         if (fast_rtx) begin
            phase_in = PHASE_RECOVERY;
            thr_in   = win_ff >> 1;
            win_in   = sum;
            resend   = 1'b1;
         end else if (dup_inc > DUP_FAST) begin
            win_in = sum;
         end
      end else begin
         dup_in      = '0;
         last_ack_in = ack_ff;
         acked       = 1'b1;
         win_in      = sum;
         if (phase_ff == PHASE_SLOW_START) begin
            if (sum >= thr_ff) phase_in = PHASE_AVOIDANCE;
         end else begin
            phase_in = PHASE_AVOIDANCE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= {{(WORD_BITS-MSS_BITS){1'b0}}, MSS_RESET};
         thr_ff       <= THR_RESET;
         phase_ff     <= PHASE_SLOW_START;
         dup_ff       <= '0;
         last_ack_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            win_ff      <= win_in;
            thr_ff      <= thr_in;
            phase_ff    <= phase_in;
            dup_ff      <= dup_in;
            last_ack_ff <= last_ack_in;
         end
         if (cmd.commit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_win_ff    <= win_in;
         out_thr_ff    <= thr_in;
         out_phase_ff  <= phase_in;
         out_resend_ff <= resend;
         out_acked_ff  <= acked;
      end
   end

   assign status.needs_div = (cmd_ff == CMD_ACK) && !is_dup && (phase_ff == PHASE_AVOIDANCE);
   assign status.div_done  = div_done;
   assign status.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid          = out_valid_ff;
   assign rsp_window         = out_win_ff;
   assign rsp_threshold      = out_thr_ff;
   assign rsp_phase          = out_phase_ff;
   assign rsp_resend_request = out_resend_ff;
   assign rsp_ack_needed     = out_acked_ff;

endmodule

// ===== rtl/reno_congestion_window.sv =====
// Reno congestion window keeper: top level joining sequencer and datapath.
// Depends on rcw_pkg, rcw_ifs, rcw_ctrl and rcw_datapath.
//
// Each request beat is an ack (command 0) or a retransmission timeout
// (command 1) and yields exactly one response beat with the updated window,
// threshold and phase. One event is handled at a time: a timeout, a duplicate
// ack, or a new ack outside congestion avoidance goes from accept through a
// decide state to commit; a new ack in congestion avoidance also starts and
// waits on the one-bit-per-cycle 32-bit divider that forms mss*mss/window. The
// response sits in an output register, so a new request is taken while it
// waits; that next event stalls in its commit state until the waiting response
// beat is taken.
// segment_size is taken from the CSR port at index 0; initial_threshold
// writes are accepted and have no effect after reset.
`timescale 1ns / 1ps

module reno_congestion_window import rcw_pkg::*; #(
   parameter int ACK_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   rcw_req_if.sink              req_chan,
   rcw_rsp_if.source            rsp_chan,
   input  logic                 csr_write_en,
   input  logic [CSR_BITS-1:0]  csr_index,
   input  logic [WORD_BITS-1:0] csr_write_data
);

   rcw_cmd_type    cmd;
   rcw_status_type status;

   rcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rcw_datapath #(
      .ACK_BITS (ACK_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_command        (req_chan.command),
      .req_ack_number     (req_chan.ack_number),
      .rsp_valid          (rsp_chan.valid),
      .rsp_ready          (rsp_chan.ready),
      .rsp_window         (rsp_chan.window),
      .rsp_threshold      (rsp_chan.threshold),
      .rsp_phase          (rsp_chan.phase),
      .rsp_resend_request (rsp_chan.resend_request),
      .rsp_ack_needed     (rsp_chan.ack_needed)
   );

endmodule

// ===== tb/sv/tb_reno_congestion_window.sv =====
// Self-checking testbench for reno_congestion_window: a directed table, then a
// duplicate-ack run past count saturation, then randomized ack/timeout traffic.
// Depends on rcw_pkg, rcw_ifs and the reno_congestion_window RTL.
`timescale 1ns / 1ps

module tb_reno_congestion_window;
   import rcw_pkg::*;

   localparam int ACK_W         = 16;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_PCT      = 23;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [WORD_BITS-1:0] window;
      logic [WORD_BITS-1:0] threshold;
      logic [1:0]           phase;
      logic                 resend_request;
      logic                 ack_needed;
   } cwnd_result_type;

   typedef enum logic [1:0] {ROW_EVENT, ROW_CHECKED, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic                 cmd;
      logic [WORD_BITS-1:0] value;
      logic [MSS_BITS-1:0]  seg;
      cwnd_result_type      result;
   } plan_row_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_BITS-1:0]  csr_index;
   logic [WORD_BITS-1:0] csr_write_data;

   rcw_req_if req_bus ();
   rcw_rsp_if rsp_bus ();

   reno_congestion_window #(.ACK_BITS(ACK_W)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_bus.sink),
      .rsp_chan       (rsp_bus.source),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // predictor state
   logic [WORD_BITS-1:0] cwnd;
   logic [WORD_BITS-1:0] ssthresh;
   logic [1:0]           cc_phase;
   logic [CNT_BITS-1:0]  dup_acks;
   logic [ACK_W-1:0]     last_ack_q;
   logic [MSS_BITS-1:0]  mss;
   logic [WORD_BITS-1:0] ssthresh_init;

   cwnd_result_type window_updates_due[$];
   plan_row_type    plan[$];
   int              fault_count = 0;
   int              quiet_cycles = 0;
   bit              steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [WORD_BITS-1:0] capped_sum(input logic [WORD_BITS-1:0] a,
                                                       input logic [63:0] b);
      logic [64:0] s;
      s = {33'd0, a} + {1'b0, b};
      return (s > 65'h0_FFFF_FFFF) ? '1 : s[WORD_BITS-1:0];
   endfunction

   function automatic cwnd_result_type predict_window_update(
         input logic cmd, input logic [WORD_BITS-1:0] ack_in);
      cwnd_result_type  r;
      logic [ACK_W-1:0] ack;
      logic [63:0]      divisor;
      logic [63:0]      square;
      ack = ack_in[ACK_W-1:0];
      r.resend_request = 1'b0;
      r.ack_needed     = 1'b0;
      if (cmd == CMD_TIMEOUT) begin
         ssthresh = cwnd / 2 + 1;
         cwnd     = {16'd0, mss};
         cc_phase = PHASE_SLOW_START;
         dup_acks = '0;
      end else if (ack == last_ack_q) begin
         if (dup_acks < DUP_MAX) dup_acks = dup_acks + 1'b1;
         if (dup_acks == DUP_FAST) begin
            cc_phase = PHASE_RECOVERY;
            ssthresh = cwnd / 2;
            cwnd     = capped_sum(ssthresh, 64'(mss) * 3);
            r.resend_request = 1'b1;
         end else if (dup_acks > DUP_FAST) begin
            cwnd = capped_sum(cwnd, 64'(mss));
         end
      end else begin
         dup_acks   = '0;
         last_ack_q = ack;
         r.ack_needed = 1'b1;
         if (cc_phase == PHASE_SLOW_START) begin
            cwnd = capped_sum(cwnd, 64'(mss));
            if (cwnd >= ssthresh) cc_phase = PHASE_AVOIDANCE;
         end else if (cc_phase == PHASE_AVOIDANCE) begin
            divisor = (cwnd == '0) ? 64'd1 : 64'(cwnd);
            square  = 64'(mss) * 64'(mss);
            cwnd    = capped_sum(cwnd, square / divisor);
         end else begin
            cwnd     = capped_sum(cwnd, 64'(mss));
            cc_phase = PHASE_AVOIDANCE;
         end
      end
      r.window    = cwnd;
      r.threshold = ssthresh;
      r.phase     = cc_phase;
      return r;
   endfunction

   function automatic logic [WORD_BITS-1:0] ack_on(input logic [ACK_W-1:0] low);
      logic [WORD_BITS-1:0] v;
      v = $urandom;
      v[ACK_W-1:0] = low;
      return v;
   endfunction

   function automatic plan_row_type event_row(input logic cmd,
                                              input logic [WORD_BITS-1:0] ack);
      plan_row_type row;
      row = '0;
      row.kind  = ROW_EVENT;
      row.cmd   = cmd;
      row.value = ack;
      return row;
   endfunction

   function automatic plan_row_type checked_row(input logic cmd,
                                                input logic [WORD_BITS-1:0] ack,
                                                input logic [WORD_BITS-1:0] w,
                                                input logic [WORD_BITS-1:0] t,
                                                input logic [1:0] ph, input logic rs,
                                                input logic an);
      plan_row_type row;
      row = event_row(cmd, ack);
      row.kind   = ROW_CHECKED;
      row.result = '{window: w, threshold: t, phase: ph, resend_request: rs, ack_needed: an};
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic [MSS_BITS-1:0] seg,
                                            input logic [WORD_BITS-1:0] thr);
      plan_row_type row;
      row = '0;
      row.kind  = ROW_CSR;
      row.seg   = seg;
      row.value = thr;
      return row;
   endfunction

   task automatic send_event(input logic cmd, input logic [WORD_BITS-1:0] ack,
                             input bit typed = 1'b0,
                             input cwnd_result_type typed_result = '0);
      cwnd_result_type want;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.ack_number <= ack;
      do @(posedge clock); while (!req_bus.ready);
      want = predict_window_update(cmd, ack);
      if (typed) want = typed_result;
      window_updates_due.push_back(want);
   endtask

   task automatic drain_updates();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (window_updates_due.size() != 0);
   endtask

   task automatic program_csrs(input logic [MSS_BITS-1:0] seg, input logic [WORD_BITS-1:0] thr);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_SEGMENT_SIZE;
      csr_write_data <= {16'd0, seg};
      @(posedge clock);
      csr_index      <= CSR_INITIAL_THRESHOLD;
      csr_write_data <= thr;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      mss           = seg;
      ssthresh_init = thr;
   endtask

   // response sink: random back-pressure
   always @(posedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin : rsp_check
      cwnd_result_type seen;
      cwnd_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = {rsp_bus.window, rsp_bus.threshold, rsp_bus.phase,
                 rsp_bus.resend_request, rsp_bus.ack_needed};
         if (window_updates_due.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
               $display("unexpected beat: w=%h t=%h ph=%0d rs=%b an=%b", seen.window,
                        seen.threshold, seen.phase, seen.resend_request, seen.ack_needed);
         end else begin
            want = window_updates_due.pop_front();
            if (seen.window !== want.window || seen.threshold !== want.threshold ||
                seen.phase !== want.phase || seen.resend_request !== want.resend_request ||
                seen.ack_needed !== want.ack_needed) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("mismatch exp %h %h %0d %b %b got %h %h %0d %b %b",
                           want.window, want.threshold, want.phase, want.resend_request,
                           want.ack_needed, seen.window, seen.threshold, seen.phase,
                           seen.resend_request, seen.ack_needed);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_reno_congestion_window NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                   random_sent;
      int                   pick;
      int                   burst;
      logic [MSS_BITS-1:0]  seg;
      logic [WORD_BITS-1:0] thr;

      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.command    <= CMD_ACK;
      req_bus.ack_number <= '0;
      csr_write_en       <= 1'b0;
      csr_index          <= CSR_SEGMENT_SIZE;
      csr_write_data     <= '0;

      cwnd          = {16'd0, MSS_RESET};
      ssthresh      = THR_RESET;
      cc_phase      = PHASE_SLOW_START;
      dup_acks      = '0;
      last_ack_q    = '0;
      mss           = MSS_RESET;
      ssthresh_init = THR_RESET;

      // duplicates of the reset ack, fast retransmit, recovery exit, timeouts
      plan.push_back(checked_row(CMD_ACK, 32'h0000_0000, 32'd1024, 32'd65535,
                                 PHASE_SLOW_START, 1'b0, 1'b0));
      plan.push_back(checked_row(CMD_ACK, 32'hFFFF_0000, 32'd1024, 32'd65535,
                                 PHASE_SLOW_START, 1'b0, 1'b0));
      plan.push_back(checked_row(CMD_ACK, 32'h0001_0000, 32'd3584, 32'd512,
                                 PHASE_RECOVERY, 1'b1, 1'b0));
      plan.push_back(event_row(CMD_ACK, 32'h8000_0000));
      plan.push_back(event_row(CMD_ACK, 32'hFFFF_FFFF));
      plan.push_back(event_row(CMD_ACK, 32'h0000_0001));
      plan.push_back(event_row(CMD_TIMEOUT, 32'hFFFF_FFFF));
      plan.push_back(event_row(CMD_ACK, 32'h0000_0002));
      plan.push_back(event_row(CMD_TIMEOUT, 32'h0000_0000));
      plan.push_back(csr_row(16'hFFFF, 32'hFFFF_FFFF));
      plan.push_back(event_row(CMD_ACK, 32'h1234_5678));
      plan.push_back(event_row(CMD_ACK, 32'hABCD_0001));
      plan.push_back(event_row(CMD_TIMEOUT, 32'h5555_AAAA));
      // zero segment size drives the window to zero
      plan.push_back(csr_row(16'h0000, 32'h0000_0001));
      plan.push_back(event_row(CMD_TIMEOUT, 32'hAAAA_5555));
      plan.push_back(event_row(CMD_ACK, 32'hFFFF_0001));
      plan.push_back(event_row(CMD_ACK, 32'h0000_0001));
      plan.push_back(checked_row(CMD_ACK, 32'h7FFF_0001, 32'd0, 32'd0,
                                 PHASE_RECOVERY, 1'b1, 1'b0));
      plan.push_back(checked_row(CMD_ACK, 32'h0000_FFFE, 32'd0, 32'd0,
                                 PHASE_AVOIDANCE, 1'b0, 1'b1));
      plan.push_back(checked_row(CMD_ACK, 32'h0000_FFFD, 32'd0, 32'd0,
                                 PHASE_AVOIDANCE, 1'b0, 1'b1));
      // zero window in avoidance: divisor of one
      plan.push_back(csr_row(16'hFFFF, 32'h8000_0000));
      plan.push_back(checked_row(CMD_ACK, 32'h0000_FFFC, 32'hFFFE_0001, 32'd0,
                                 PHASE_AVOIDANCE, 1'b0, 1'b1));
      plan.push_back(checked_row(CMD_ACK, 32'h0000_FFFC, 32'hFFFE_0001, 32'd0,
                                 PHASE_AVOIDANCE, 1'b0, 1'b0));
      plan.push_back(event_row(CMD_ACK, 32'hFFFF_FFFC));
      plan.push_back(checked_row(CMD_ACK, 32'h1111_FFFC, 32'h8001_FFFD, 32'h7FFF_0000,
                                 PHASE_RECOVERY, 1'b1, 1'b0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_CSR: begin
               drain_updates();
               program_csrs(plan[i].seg, plan[i].value);
            end
            ROW_CHECKED: send_event(plan[i].cmd, plan[i].value, 1'b1, plan[i].result);
            default:     send_event(plan[i].cmd, plan[i].value);
         endcase
      end

      // duplicate run: the count saturates at its maximum
      repeat (260) send_event(CMD_ACK, ack_on(last_ack_q));
      send_event(CMD_ACK, ack_on(last_ack_q + 1'b1));
      send_event(CMD_ACK, ack_on(last_ack_q + 1'b1));
      send_event(CMD_TIMEOUT, $urandom);

      random_sent = 0;
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0:       begin seg = 16'd1;     thr = 32'd1;           end
            1:       begin seg = 16'hFFFF;  thr = 32'hFFFF_FFFF;   end
            2:       begin seg = 16'($urandom_range(1, 65535)); thr = $urandom; end
            3:       begin seg = 16'd1460;  thr = 32'd65535;       end
            default: begin
               seg = 16'($urandom_range(1, 2048));
               thr = 32'($urandom_range(1, 1 << 20));
            end
         endcase
         drain_updates();
         program_csrs(seg, thr);
         for (int n = 0; n < 220; ) begin
            steady = (random_sent >= 500 && random_sent < 800);
            pick = $urandom_range(99);
            if (pick < 5) begin
               send_event(CMD_TIMEOUT, $urandom);
               burst = 1;
            end else if (pick < 12) begin
               send_event(CMD_ACK, $urandom);
               burst = 1;
            end else if (pick < 40) begin
               burst = $urandom_range(1, 6);
               repeat (burst) send_event(CMD_ACK, ack_on(last_ack_q));
            end else begin
               send_event(CMD_ACK, ack_on(last_ack_q + ACK_W'($urandom_range(1, 2920))));
               burst = 1;
            end
            n += burst;
            random_sent += burst;
            if ($urandom_range(99) < 2) drain_updates();
         end
      end
      steady = 1'b0;

      drain_updates();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0 && window_updates_due.size() == 0) begin
         $display("tb_reno_congestion_window OK");
      end else begin
         $display("tb_reno_congestion_window NOT OK");
      end
      $finish;
   end

endmodule

// ===== reno_congestion_window.f =====
rtl/rcw_pkg.sv
rtl/rcw_ifs.sv
rtl/rcw_divider.sv
rtl/rcw_ctrl.sv
rtl/rcw_datapath.sv
rtl/reno_congestion_window.sv
tb/sv/tb_reno_congestion_window.sv
